/* rtl/core/v3alu_pkg.sv */
// Shared types, command codes and saturation helper for the vector ALU.
// Used by every module of the block; no dependencies.
package v3alu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int SAT_W = 67;

	localparam logic [3:0] CMD_ADD       = 4'd0;
	localparam logic [3:0] CMD_SUB       = 4'd1;
	localparam logic [3:0] CMD_SCALE     = 4'd2;
	localparam logic [3:0] CMD_DOT       = 4'd3;
	localparam logic [3:0] CMD_CROSS     = 4'd4;
	localparam logic [3:0] CMD_NORM      = 4'd5;
	localparam logic [3:0] CMD_NORMALIZE = 4'd6;
	localparam logic [3:0] CMD_DIST      = 4'd7;
	localparam logic [3:0] CMD_EQUAL     = 4'd8;

	localparam logic [31:0] WORD_MAX = 32'h7fff_ffff;
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;

	localparam logic signed [SAT_W-1:0] SAT_MAX = {{(SAT_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SAT_W-1:0] SAT_MIN = {{(SAT_W-31){1'b1}}, {31{1'b0}}};

	typedef struct packed {
		logic [3:0]         command;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] bz;
		logic signed [31:0] factor;
	} req_t;

	typedef struct packed {
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] scalar;
		logic               saturated;
		logic               null_error;
	} rsp_t;

	// partial result traveling with an item; vx..vz hold magnitudes for normalize
	typedef struct packed {
		logic [3:0]  cmd;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [31:0] sc;
		logic        sat;
		logic [2:0]  neg;
	} side_t;

	// {clamped, value}
	function automatic logic [32:0] sat_word(input logic signed [SAT_W-1:0] v);
		logic [32:0] r;
		if (v > SAT_MAX)
			r = {1'b1, WORD_MAX};
		else if (v < SAT_MIN)
			r = {1'b1, WORD_MIN};
		else
			r = {1'b0, v[31:0]};
		return r;
	endfunction

endpackage

/* rtl/core/v3alu_if.sv */
// Valid/ready channel carrying one item of payload type T.
// No dependencies.
interface v3alu_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/v3alu_front.sv */
// Front pipeline: operand select, six multipliers, sums, rounding and clamping.
// Four register stages; depends on v3alu_pkg.
module v3alu_front #(
	parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  v3alu_pkg::req_t     req_in,
	output logic                vld_out,
	output v3alu_pkg::side_t    side_out,
	output logic [63:0]         sq_out
);
	import v3alu_pkg::*;

	localparam logic signed [65:0] RND = 66'sd1 <<< (FRAC_BITS - 1);

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	side_t             side_c1, side_s1, side_s2, side_c3, side_s3, side_c4, side_s4;
	logic signed [32:0] ma_c [6];
	logic signed [32:0] mb_c [6];
	logic signed [32:0] ma_s1 [6];
	logic signed [32:0] mb_s1 [6];
	logic signed [63:0] prod_c [6];
	logic signed [63:0] prod_s2 [6];
	logic signed [65:0] sx_c, sy_c, sz_c, sx_s3, sy_s3, sz_s3;
	logic [63:0]       sq_c, sq_s3, sq_s4;

	// stage 1: add/sub, equality, distance range check, multiplier operands
	always_comb begin
		logic signed [32:0] sum_x, sum_y, sum_z, dx, dy, dz;
		logic [32:0] rx, ry, rz;
		logic [31:0] ux, uy, uz;
		logic dovf;
		sum_x = 33'(req_in.ax) + 33'(req_in.bx);
		sum_y = 33'(req_in.ay) + 33'(req_in.by);
		sum_z = 33'(req_in.az) + 33'(req_in.bz);
		dx = 33'(req_in.ax) - 33'(req_in.bx);
		dy = 33'(req_in.ay) - 33'(req_in.by);
		dz = 33'(req_in.az) - 33'(req_in.bz);
		ux = req_in.ax;
		uy = req_in.ay;
		uz = req_in.az;
		dovf = (dx[32] ^ dx[31]) || (dx == 33'h1_8000_0000)
			|| (dy[32] ^ dy[31]) || (dy == 33'h1_8000_0000)
			|| (dz[32] ^ dz[31]) || (dz == 33'h1_8000_0000);
		rx = '0;
		ry = '0;
		rz = '0;
		side_c1 = '0;
		side_c1.cmd = req_in.command;
		for (int j = 0; j < 6; j++) begin
			ma_c[j] = '0;
			mb_c[j] = '0;
		end
		case (req_in.command)
			CMD_ADD: begin
				rx = sat_word(SAT_W'(sum_x));
				ry = sat_word(SAT_W'(sum_y));
				rz = sat_word(SAT_W'(sum_z));
			end
			CMD_SUB: begin
				rx = sat_word(SAT_W'(dx));
				ry = sat_word(SAT_W'(dy));
				rz = sat_word(SAT_W'(dz));
			end
			CMD_SCALE: begin
				ma_c[0] = 33'(req_in.ax); mb_c[0] = 33'(req_in.factor);
				ma_c[1] = 33'(req_in.ay); mb_c[1] = 33'(req_in.factor);
				ma_c[2] = 33'(req_in.az); mb_c[2] = 33'(req_in.factor);
			end
			CMD_DOT: begin
				ma_c[0] = 33'(req_in.ax); mb_c[0] = 33'(req_in.bx);
				ma_c[1] = 33'(req_in.ay); mb_c[1] = 33'(req_in.by);
				ma_c[2] = 33'(req_in.az); mb_c[2] = 33'(req_in.bz);
			end
			CMD_CROSS: begin
				ma_c[0] = 33'(req_in.ay); mb_c[0] = 33'(req_in.bz);
				ma_c[1] = 33'(req_in.az); mb_c[1] = 33'(req_in.bx);
				ma_c[2] = 33'(req_in.ax); mb_c[2] = 33'(req_in.by);
				ma_c[3] = 33'(req_in.az); mb_c[3] = 33'(req_in.by);
				ma_c[4] = 33'(req_in.ax); mb_c[4] = 33'(req_in.bz);
				ma_c[5] = 33'(req_in.ay); mb_c[5] = 33'(req_in.bx);
			end
			CMD_NORM, CMD_NORMALIZE: begin
				ma_c[0] = 33'(req_in.ax); mb_c[0] = 33'(req_in.ax);
				ma_c[1] = 33'(req_in.ay); mb_c[1] = 33'(req_in.ay);
				ma_c[2] = 33'(req_in.az); mb_c[2] = 33'(req_in.az);
			end
			CMD_DIST: begin
				ma_c[0] = dx; mb_c[0] = dx;
				ma_c[1] = dy; mb_c[1] = dy;
				ma_c[2] = dz; mb_c[2] = dz;
			end
			default: ;
		endcase
		case (req_in.command) inside
			CMD_ADD, CMD_SUB: begin
				side_c1.vx = rx[31:0];
				side_c1.vy = ry[31:0];
				side_c1.vz = rz[31:0];
				side_c1.sat = rx[32] | ry[32] | rz[32];
			end
			CMD_NORMALIZE: begin
				side_c1.vx = ux[31] ? (~ux + 32'd1) : ux;
				side_c1.vy = uy[31] ? (~uy + 32'd1) : uy;
				side_c1.vz = uz[31] ? (~uz + 32'd1) : uz;
				side_c1.neg = {uz[31], uy[31], ux[31]};
			end
			CMD_DIST: begin
				side_c1.sat = dovf;
				side_c1.sc = dovf ? WORD_MAX : 32'd0;
			end
			CMD_EQUAL: begin
				side_c1.sc = {31'd0, (req_in.ax == req_in.bx) && (req_in.ay == req_in.by)
					&& (req_in.az == req_in.bz)};
			end
			default: ;
		endcase
	end

	// stage 2: products
	always_comb begin
		logic signed [65:0] full;
		for (int j = 0; j < 6; j++) begin
			full = ma_s1[j] * mb_s1[j];
			prod_c[j] = full[63:0];
		end
	end

	// stage 3: sums of products
	always_comb begin
		logic signed [65:0] p [6];
		for (int j = 0; j < 6; j++)
			p[j] = 66'(prod_s2[j]);
		case (side_s2.cmd) inside
			CMD_CROSS: begin
				sx_c = p[0] - p[3];
				sy_c = p[1] - p[4];
				sz_c = p[2] - p[5];
			end
			CMD_DOT: begin
				sx_c = p[0] + p[1] + p[2];
				sy_c = '0;
				sz_c = '0;
			end
			default: begin
				sx_c = p[0];
				sy_c = p[1];
				sz_c = p[2];
			end
		endcase
		sq_c = $unsigned(prod_s2[0]) + $unsigned(prod_s2[1]) + $unsigned(prod_s2[2]);
		side_c3 = side_s2;
	end

	// stage 4: round to nearest and clamp
	always_comb begin
		logic [32:0] rx, ry, rz;
		rx = sat_word(SAT_W'((sx_s3 + RND) >>> FRAC_BITS));
		ry = sat_word(SAT_W'((sy_s3 + RND) >>> FRAC_BITS));
		rz = sat_word(SAT_W'((sz_s3 + RND) >>> FRAC_BITS));
		side_c4 = side_s3;
		case (side_s3.cmd) inside
			CMD_SCALE, CMD_CROSS: begin
				side_c4.vx = rx[31:0];
				side_c4.vy = ry[31:0];
				side_c4.vz = rz[31:0];
				side_c4.sat = rx[32] | ry[32] | rz[32];
			end
			CMD_DOT: begin
				side_c4.sc = rx[31:0];
				side_c4.sat = rx[32];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side_c1;
			for (int j = 0; j < 6; j++) begin
				ma_s1[j] <= ma_c[j];
				mb_s1[j] <= mb_c[j];
				prod_s2[j] <= prod_c[j];
			end
			side_s2 <= side_s1;
			side_s3 <= side_c3;
			sx_s3 <= sx_c;
			sy_s3 <= sy_c;
			sz_s3 <= sz_c;
			sq_s3 <= sq_c;
			side_s4 <= side_c4;
			sq_s4 <= sq_s3;
		end
	end

	assign vld_out = vld_s4;
	assign side_out = side_s4;
	assign sq_out = sq_s4;

endmodule

/* rtl/core/v3alu_sqrt.sv */
// Pipelined integer square root, one root bit per stage, then round to nearest.
// 33 register stages; depends on v3alu_pkg.
module v3alu_sqrt (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  v3alu_pkg::side_t side_in,
	input  logic [63:0]      sq_in,
	output logic             vld_out,
	output v3alu_pkg::side_t side_out,
	output logic [32:0]      n_out
);
	import v3alu_pkg::*;

	localparam int NSQ = 32;

	logic [NSQ-1:0] vld_s;
	side_t          side_s [NSQ];
	logic [63:0]    rem_s [NSQ];
	logic [63:0]    root_s [NSQ];
	logic [63:0]    rem_n [NSQ];
	logic [63:0]    root_n [NSQ];
	logic           vld_sr;
	side_t          side_sr;
	logic [32:0]    n_sr;
	logic [32:0]    n_c;

	always_comb begin
		logic [63:0] ri, qi, bitk, trial;
		for (int k = 0; k < NSQ; k++) begin
			if (k == 0) begin
				ri = sq_in;
				qi = '0;
			end else begin
				ri = rem_s[k-1];
				qi = root_s[k-1];
			end
			bitk = 64'd1 << (62 - 2 * k);
			trial = qi + bitk;
			if (ri >= trial) begin
				rem_n[k] = ri - trial;
				root_n[k] = (qi >> 1) + bitk;
			end else begin
				rem_n[k] = ri;
				root_n[k] = qi >> 1;
			end
		end
		n_c = {1'b0, root_s[NSQ-1][31:0]} + 33'(rem_s[NSQ-1] > root_s[NSQ-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_sr <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[NSQ-2:0], vld_in};
			vld_sr <= vld_s[NSQ-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 0; k < NSQ; k++) begin
				rem_s[k] <= rem_n[k];
				root_s[k] <= root_n[k];
			end
			for (int k = 1; k < NSQ; k++)
				side_s[k] <= side_s[k-1];
			side_sr <= side_s[NSQ-1];
			n_sr <= n_c;
		end
	end

	assign vld_out = vld_sr;
	assign side_out = side_sr;
	assign n_out = n_sr;

endmodule

/* rtl/core/v3alu_div.sv */
// Norm/distance clamp, pipelined restoring dividers for normalize, result assembly.
// 32+FRAC_BITS+2 register stages; depends on v3alu_pkg.
module v3alu_div #(
	parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_in,
	input  v3alu_pkg::side_t side_in,
	input  logic [32:0]      n_in,
	output logic             vld_out,
	output v3alu_pkg::rsp_t  rsp_out
);
	import v3alu_pkg::*;

	localparam int NW = 32 + FRAC_BITS;

	logic [NW:0]    vld_s;
	side_t          side_s [NW+1];
	side_t          side_n [NW+1];
	logic [32:0]    n_s [NW+1];
	logic [32:0]    rem_s [NW+1][3];
	logic [32:0]    rem_n [NW+1][3];
	logic [NW-1:0]  acc_s [NW+1][3];
	logic [NW-1:0]  acc_n [NW+1][3];
	logic           vld_sf;
	rsp_t           rsp_sf;
	rsp_t           rsp_c;

	// entry stage: clamp norm and distance, build numerators;
	// divider stages: one quotient bit per stage and lane
	always_comb begin
		logic        nsat;
		logic [31:0] nword;
		logic [31:0] mag [3];
		logic [33:0] t;
		logic        ge;
		nsat = n_in > {1'b0, WORD_MAX};
		nword = nsat ? WORD_MAX : n_in[31:0];
		mag[0] = side_in.vx;
		mag[1] = side_in.vy;
		mag[2] = side_in.vz;
		side_n[0] = side_in;
		case (side_in.cmd) inside
			CMD_NORM: begin
				side_n[0].sc = nword;
				side_n[0].sat = nsat;
			end
			CMD_DIST: begin
				if (!side_in.sat) begin
					side_n[0].sc = nword;
					side_n[0].sat = nsat;
				end
			end
			default: ;
		endcase
		for (int j = 0; j < 3; j++) begin
			rem_n[0][j] = '0;
			acc_n[0][j] = (NW'(mag[j]) << FRAC_BITS) + NW'(n_in >> 1);
		end
		for (int k = 1; k <= NW; k++) begin
			side_n[k] = side_s[k-1];
			for (int j = 0; j < 3; j++) begin
				t = {rem_s[k-1][j], acc_s[k-1][j][NW-1]};
				ge = t >= {1'b0, n_s[k-1]};
				rem_n[k][j] = ge ? 33'(t - {1'b0, n_s[k-1]}) : t[32:0];
				acc_n[k][j] = {acc_s[k-1][j][NW-2:0], ge};
			end
		end
	end

	// final stage: sign, clamp and select
	always_comb begin
		logic [31:0] res [3];
		logic [NW-1:0] q;
		logic ovf, any;
		any = 1'b0;
		for (int j = 0; j < 3; j++) begin
			q = acc_s[NW][j];
			if (side_s[NW].neg[j]) begin
				ovf = q > NW'(64'h8000_0000);
				res[j] = ovf ? WORD_MIN : (~q[31:0] + 32'd1);
			end else begin
				ovf = q > NW'(WORD_MAX);
				res[j] = ovf ? WORD_MAX : q[31:0];
			end
			any = any | ovf;
		end
		rsp_c.rx = side_s[NW].vx;
		rsp_c.ry = side_s[NW].vy;
		rsp_c.rz = side_s[NW].vz;
		rsp_c.scalar = side_s[NW].sc;
		rsp_c.saturated = side_s[NW].sat;
		rsp_c.null_error = 1'b0;
		if (side_s[NW].cmd == CMD_NORMALIZE) begin
			if (n_s[NW] == '0) begin
				rsp_c.rx = '0;
				rsp_c.ry = '0;
				rsp_c.rz = '0;
				rsp_c.saturated = 1'b0;
				rsp_c.null_error = 1'b1;
			end else begin
				rsp_c.rx = res[0];
				rsp_c.ry = res[1];
				rsp_c.rz = res[2];
				rsp_c.saturated = any;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
			vld_sf <= 1'b0;
		end else if (en) begin
			vld_s <= {vld_s[NW-1:0], vld_in};
			vld_sf <= vld_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0] <= n_in;
			for (int k = 0; k <= NW; k++) begin
				side_s[k] <= side_n[k];
				for (int j = 0; j < 3; j++) begin
					rem_s[k][j] <= rem_n[k][j];
					acc_s[k][j] <= acc_n[k][j];
				end
			end
			for (int k = 1; k <= NW; k++)
				n_s[k] <= n_s[k-1];
			rsp_sf <= rsp_c;
		end
	end

	assign vld_out = vld_sf;
	assign rsp_out = rsp_sf;

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_sf && rsp_sf.null_error |-> rsp_sf.rx == '0 && rsp_sf.ry == '0
			&& rsp_sf.rz == '0 && !rsp_sf.saturated)
		else $error("null_error item carries a nonzero vector");

	a_null_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[NW] && side_s[NW].cmd != CMD_NORMALIZE |=> !rsp_sf.null_error)
		else $error("null_error raised outside normalize");

endmodule

/* rtl/core/v3alu_obuf.sv */
// Two-entry output buffer; decouples the pipeline advance from the result ready.
// Depends on v3alu_pkg and v3alu_if.
module v3alu_obuf (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vld_in,
	input  v3alu_pkg::rsp_t din,
	output logic            en,
	v3alu_if.source         rsp
);
	import v3alu_pkg::*;

	logic [1:0] cnt_q;
	rsp_t       b0_q, b1_q;
	logic       push, pop;

	assign en = cnt_q != 2'd2;
	assign push = en && vld_in;
	assign pop = (cnt_q != 2'd0) && rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 2'd0;
		else
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cnt_q == 2'd2)
				b0_q <= b1_q;
			else if (push)
				b0_q <= din;
		end else if (push) begin
			if (cnt_q == 2'd0)
				b0_q <= din;
			else
				b1_q <= din;
		end
	end

	assign rsp.valid = cnt_q != 2'd0;
	assign rsp.data = b0_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output buffer count out of range");

endmodule

/* rtl/core/vector3_fixed_point_alu_unit.sv */
// Three-component Q-format vector ALU: add, sub, scale, dot, cross, norm, normalize,
// distance, equal. Stages from acceptance to result valid: 4 front-pipeline stages,
// 33 square-root stages, 34+FRAC_BITS divider stages, 1 output buffer stage. Throughput
// one item per cycle while the output buffer has room; the divider chain sets the depth.
// Reset clears all valid bits and the output buffer; no other state.
module vector3_fixed_point_alu_unit #(
	parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
	input logic     clk,
	input logic     arst_n,
	v3alu_if.sink   req,
	v3alu_if.source rsp
);
	import v3alu_pkg::*;

	logic        en;
	logic        vld_f, vld_q;
	side_t       side_f, side_q;
	logic [63:0] sq_f;
	logic [32:0] n_q;
	logic        vld_d;
	rsp_t        rsp_d;

	assign req.ready = en;

	v3alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (req.valid),
		.req_in   (req.data),
		.vld_out  (vld_f),
		.side_out (side_f),
		.sq_out   (sq_f)
	);

	v3alu_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_f),
		.side_in  (side_f),
		.sq_in    (sq_f),
		.vld_out  (vld_q),
		.side_out (side_q),
		.n_out    (n_q)
	);

	v3alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (vld_q),
		.side_in (side_q),
		.n_in    (n_q),
		.vld_out (vld_d),
		.rsp_out (rsp_d)
	);

	v3alu_obuf u_obuf (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_in (vld_d),
		.din    (rsp_d),
		.en     (en),
		.rsp    (rsp)
	);

endmodule

/* bench/tb_vector3_fixed_point_alu_unit.sv */
// Self-checking bench for the three-component fixed-point vector ALU.
// Drives requests through v3alu_if, predicts each response in place and compares them.
// Depends on v3alu_pkg, v3alu_if and vector3_fixed_point_alu_unit.
`timescale 1ns / 1ps
module tb_vector3_fixed_point_alu_unit;
	import v3alu_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 71 + FB;
	localparam longint CYCLE_LIMIT = 200000;

	typedef struct {
		req_t req;
		bit   has_rsp;
		rsp_t rsp;
	} vec_row_t;

	logic clk;
	logic arst_n;
	longint cycle_cnt;
	int err_cnt;
	int sent_cnt;
	int got_cnt;
	rsp_t expected_q[$];
	vec_row_t rows[$];

	v3alu_if #(.T(req_t)) req_ch ();
	v3alu_if #(.T(rsp_t)) rsp_ch ();

	vector3_fixed_point_alu_unit #(.FRAC_BITS(FB)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic logic signed [31:0] clamp(input logic signed [127:0] v, ref bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [127:0] round_shift(input logic signed [127:0] v);
		return (v + (128'sd1 <<< (FB - 1))) >>> FB;
	endfunction

	function automatic logic [127:0] root_nearest(input logic [127:0] s);
		logic [127:0] r;
		logic [127:0] b;
		r = 0;
		for (int i = 63; i >= 0; i--) begin
			b = r | (128'd1 << i);
			if (b * b <= s)
				r = b;
		end
		if (s - r * r > r)
			r = r + 1;
		return r;
	endfunction

	function automatic rsp_t vec_alu_predict(input req_t q);
		rsp_t o;
		bit sat;
		logic signed [127:0] a[3];
		logic signed [127:0] b[3];
		logic signed [127:0] d[3];
		logic signed [31:0] w[3];
		logic signed [127:0] f;
		logic [127:0] n;
		logic [127:0] num;
		logic signed [127:0] qv;
		o = '0;
		sat = 0;
		a[0] = 128'(q.ax); a[1] = 128'(q.ay); a[2] = 128'(q.az);
		b[0] = 128'(q.bx); b[1] = 128'(q.by); b[2] = 128'(q.bz);
		f = 128'(q.factor);
		case (q.command)
			CMD_ADD: begin
				o.rx = clamp(a[0] + b[0], sat);
				o.ry = clamp(a[1] + b[1], sat);
				o.rz = clamp(a[2] + b[2], sat);
			end
			CMD_SUB: begin
				o.rx = clamp(a[0] - b[0], sat);
				o.ry = clamp(a[1] - b[1], sat);
				o.rz = clamp(a[2] - b[2], sat);
			end
			CMD_SCALE: begin
				o.rx = clamp(round_shift(a[0] * f), sat);
				o.ry = clamp(round_shift(a[1] * f), sat);
				o.rz = clamp(round_shift(a[2] * f), sat);
			end
			CMD_DOT: o.scalar = clamp(round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]), sat);
			CMD_CROSS: begin
				o.rx = clamp(round_shift(a[1] * b[2] - a[2] * b[1]), sat);
				o.ry = clamp(round_shift(a[2] * b[0] - a[0] * b[2]), sat);
				o.rz = clamp(round_shift(a[0] * b[1] - a[1] * b[0]), sat);
			end
			CMD_NORM: o.scalar = clamp(root_nearest(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]), sat);
			CMD_NORMALIZE: begin
				n = root_nearest(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
				if (n == 0) begin
					o.null_error = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++) begin
						num = (a[i] < 0 ? -a[i] : a[i]) << FB;
						qv = (num + (n >> 1)) / n;
						w[i] = clamp(a[i] < 0 ? -qv : qv, sat);
					end
					o.rx = w[0]; o.ry = w[1]; o.rz = w[2];
				end
			end
			CMD_DIST: begin
				for (int i = 0; i < 3; i++)
					d[i] = a[i] - b[i];
				if (d[0] > 128'sd2147483647 || d[0] < -128'sd2147483647 ||
				    d[1] > 128'sd2147483647 || d[1] < -128'sd2147483647 ||
				    d[2] > 128'sd2147483647 || d[2] < -128'sd2147483647) begin
					sat = 1'b1;
					o.scalar = 32'sh7fff_ffff;
				end else begin
					o.scalar = clamp(root_nearest(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]), sat);
				end
			end
			CMD_EQUAL: o.scalar = (q.ax == q.bx && q.ay == q.by && q.az == q.bz) ? 32'sd1 : 32'sd0;
			default: ;
		endcase
		o.saturated = sat;
		return o;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch on item %0d: %s got %h want %h", got_cnt, what, got, want);
		err_cnt++;
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fff_ffff - $urandom_range(0, 3);
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h0003_ffff)
				: -$urandom_range(0, 32'h0003_ffff);
			3: return 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
			default: return $urandom;
		endcase
	endfunction

	function automatic req_t rnd_req();
		req_t q;
		q.command = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(CMD_ADD, CMD_EQUAL));
		q.ax = rnd_word(); q.ay = rnd_word(); q.az = rnd_word();
		q.bx = rnd_word(); q.by = rnd_word(); q.bz = rnd_word();
		q.factor = rnd_word();
		case ($urandom_range(0, 7))
			0: begin q.bx = q.ax; q.by = q.ay; q.bz = q.az; end
			1: begin q.ax = 0; q.ay = 0; q.az = 0; end
			2: begin
				q.bx = q.ax + $urandom_range(0, 2) - 1;
				q.by = q.ay; q.bz = q.az;
			end
			default: ;
		endcase
		return q;
	endfunction

	function automatic vec_row_t row(input logic [3:0] c, input logic [31:0] ax, ay, az,
		bx, by, bz, f);
		vec_row_t r;
		r.req = '{c, ax, ay, az, bx, by, bz, f};
		r.has_rsp = 1'b0;
		r.rsp = '0;
		return r;
	endfunction

	function automatic vec_row_t row_exp(input vec_row_t r, input logic [31:0] x, y, z, s,
		input logic sat, input logic nul);
		r.has_rsp = 1'b1;
		r.rsp = '{x, y, z, s, sat, nul};
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("tb_vector3_fixed_point_alu_unit NOT OK");
			$finish;
		end
	end

	// response side: check and randomly stall
	initial begin
		int gap;
		rsp_t want;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_q.size() == 0) begin
					$display("unexpected response");
					err_cnt++;
				end else begin
					want = expected_q.pop_front();
					if (rsp_ch.data.rx !== want.rx) report("rx", rsp_ch.data.rx, want.rx);
					if (rsp_ch.data.ry !== want.ry) report("ry", rsp_ch.data.ry, want.ry);
					if (rsp_ch.data.rz !== want.rz) report("rz", rsp_ch.data.rz, want.rz);
					if (rsp_ch.data.scalar !== want.scalar)
						report("scalar", rsp_ch.data.scalar, want.scalar);
					if (rsp_ch.data.saturated !== want.saturated)
						report("saturated", 32'(rsp_ch.data.saturated), 32'(want.saturated));
					if (rsp_ch.data.null_error !== want.null_error)
						report("null_error", 32'(rsp_ch.data.null_error),
							32'(want.null_error));
				end
				got_cnt++;
			end
			gap = ((got_cnt / 100) % 3 == 0) ? 0 : $urandom_range(0, 5);
			rsp_ch.ready <= (gap == 0) || ($urandom_range(0, gap) == 0);
		end
	end

	initial begin
		int gap;
		vec_row_t r;
		cycle_cnt = 0;
		err_cnt = 0;
		sent_cnt = 0;
		got_cnt = 0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(row_exp(row(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 1, 1, 32'hffff_ffff, 2,
			0), 32'h7fff_ffff, 32'h8000_0000, 3, 0, 1, 0));
		rows.push_back(row_exp(row(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 5, 1, 32'hffff_ffff, 2,
			0), 32'h8000_0000, 32'h7fff_ffff, 3, 0, 1, 0));
		rows.push_back(row_exp(row(CMD_NORMALIZE, 0, 0, 0, 7, 7, 7, 7), 0, 0, 0, 0, 0, 1));
		rows.push_back(row_exp(row(CMD_EQUAL, 5, 6, 7, 5, 6, 7, 0), 0, 0, 0, 1, 0, 0));
		rows.push_back(row_exp(row(CMD_EQUAL, 5, 6, 7, 5, 6, 8, 0), 0, 0, 0, 0, 0, 0));
		rows.push_back(row_exp(row(CMD_DIST, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 0),
			0, 0, 0, 32'h7fff_ffff, 1, 0));
		rows.push_back(row_exp(row(4'd9, 1, 2, 3, 4, 5, 6, 7), 0, 0, 0, 0, 0, 0));
		rows.push_back(row_exp(row(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff), 0, 0, 0, 0, 0, 0));
		rows.push_back(row_exp(row(CMD_NORM, 32'h0001_0000, 0, 0, 0, 0, 0, 0),
			0, 0, 0, 32'h0001_0000, 0, 0));
		rows.push_back(row(CMD_SCALE, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_8000, 0, 0, 0,
			32'h8000_0000));
		rows.push_back(row(CMD_SCALE, 3, 32'hffff_fffd, 1, 0, 0, 0, 32'h0000_8000));
		rows.push_back(row(CMD_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
		rows.push_back(row(CMD_DOT, 32'h0001_8000, 32'h0000_0001, 32'hfffe_0000,
			32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 0));
		rows.push_back(row(CMD_CROSS, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0));
		rows.push_back(row(CMD_CROSS, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0));
		rows.push_back(row(CMD_NORM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
		rows.push_back(row(CMD_NORMALIZE, 32'h8000_0000, 32'h7fff_ffff, 1, 0, 0, 0, 0));
		rows.push_back(row(CMD_NORMALIZE, 0, 0, 1, 0, 0, 0, 0));
		rows.push_back(row(CMD_NORMALIZE, 32'h0003_0000, 32'hfffc_0000, 0, 0, 0, 0, 0));
		rows.push_back(row(CMD_DIST, 32'h0003_0000, 0, 0, 0, 32'h0004_0000, 0, 0));
		rows.push_back(row(CMD_DIST, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000,
			32'hc000_0001, 32'hc000_0001, 32'hc000_0001, 0));
		for (int i = 0; i < 830; i++)
			rows.push_back(row(CMD_ADD, 0, 0, 0, 0, 0, 0, 0));
		for (int i = 21; i < rows.size(); i++)
			rows[i].req = rnd_req();

		foreach (rows[i]) begin
			r = rows[i];
			if (!r.has_rsp)
				r.rsp = vec_alu_predict(r.req);
			else if (vec_alu_predict(r.req) != r.rsp) begin
				$display("directed row %0d disagrees with prediction", i);
				err_cnt++;
			end
			gap = ((i / 120) % 3 == 1) ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req_ch.valid <= 1'b1;
			req_ch.data <= r.req;
			expected_q.push_back(r.rsp);
			@(posedge clk);
			while (!req_ch.ready) @(posedge clk);
			sent_cnt++;
		end
		req_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		$display("sent %0d items over all nine commands and unknown codes, %0d responses checked",
			sent_cnt, got_cnt);
		if (err_cnt == 0)
			$display("tb_vector3_fixed_point_alu_unit OK");
		else
			$display("tb_vector3_fixed_point_alu_unit NOT OK");
		$finish;
	end

endmodule
